// File: src/lr_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies; used by lr_setup, lr_step and line_rasterizer.
`default_nettype none

package lr_pkg;

  // Register file geometry
  localparam int DIM_W       = 11;
  localparam int SHIFT_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  // Result payload widths
  localparam int ADDR_W     = 21;
  localparam int COLOR_W    = 16;
  localparam int OUT_DATA_W = ((ADDR_W + COLOR_W + 7) / 8) * 8;

  // Register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_SHIFT     = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0]   SCREEN_WIDTH_RST  = 11'd320;
  localparam logic [DIM_W-1:0]   SCREEN_HEIGHT_RST = 11'd240;
  localparam logic [SHIFT_W-1:0] ROW_SHIFT_RST     = 4'd9;

  // Request kinds carried on the input tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Line orientation flags produced by the setup logic
  typedef struct packed {
    logic steep;
    logic minor_down;
    logic active;
  } setup_flags_t;

  // Per-step status produced by the step logic
  typedef struct packed {
    logic pixel_valid;
    logic line_finished;
  } step_status_t;

endpackage

`default_nettype wire

// File: src/line_rasterizer.sv
// Top level of the Bresenham line rasterizer: channels, input and result
// registers, line state and configuration registers. Uses lr_pkg, lr_setup, lr_step.
//
//  channel  | direction | contents
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | tuser: req_type; tdata: x_start, y_start, x_end, y_end, color
//  m_axis   | out       | tuser: pixel_valid; tlast: line_finished;
//           |           | tdata: pixel_address, pixel_color
//  cfg      | in        | cfg_index selects screen_width, screen_height, row_shift
//
// One word per clock sustained while m_axis does not stall; a word is captured in the
// input register when it is accepted and its result in the result register when it
// advances, with the line state updated by the combinational setup or step logic.
// Reset clears the line to idle and loads the default screen geometry.
// A stalled result holds the result register; one more word waits in the input
// register, and s_axis_tready drops only when both are full and m_axis stalls.
`default_nettype none

module line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: x_start, y_start, x_end, y_end, color, zero fill
  input  wire logic [((4*COORD_BITS+lr_pkg::COLOR_W+7)/8)*8-1:0] s_axis_tdata,
  // tuser: req_type
  input  wire logic                            s_axis_tuser,
  // Result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata from bit 0: pixel_address, pixel_color, zero fill
  output logic [lr_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // tuser: pixel_valid
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast,
  // Configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [lr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IN_DATA_W = ((4*COORD_BITS + lr_pkg::COLOR_W + 7) / 8) * 8;
  localparam int XS_LO     = 0;
  localparam int YS_LO     = COORD_BITS;
  localparam int XE_LO     = 2 * COORD_BITS;
  localparam int YE_LO     = 3 * COORD_BITS;
  localparam int COLOR_LO  = 4 * COORD_BITS;
  localparam int ADDR_W    = lr_pkg::ADDR_W;
  localparam int COLOR_W   = lr_pkg::COLOR_W;

  // Configuration registers
  logic [lr_pkg::DIM_W-1:0]   screen_width;
  logic [lr_pkg::DIM_W-1:0]   screen_height;
  logic [lr_pkg::SHIFT_W-1:0] row_shift;

  // Input register
  logic                 in_valid;
  logic                 in_req;
  logic [IN_DATA_W-1:0] in_data;

  // Line state
  logic                         active;
  logic                         steep;
  logic                         minor_down;
  logic [COORD_BITS-1:0]        major_pos;
  logic [COORD_BITS-1:0]        major_end;
  logic [COORD_BITS-1:0]        minor_pos;
  logic [COORD_BITS-1:0]        major_delta;
  logic [COORD_BITS-1:0]        minor_delta;
  logic signed [COORD_BITS+1:0] error_term;
  logic [COLOR_W-1:0]           line_color;

  // Result register
  logic                           out_valid;
  logic                           out_pixel;
  logic                           out_last;
  logic [lr_pkg::OUT_DATA_W-1:0]  out_data;

  // Setup and step results
  lr_pkg::setup_flags_t         setup_flags;
  logic [COORD_BITS-1:0]        setup_major_pos;
  logic [COORD_BITS-1:0]        setup_major_end;
  logic [COORD_BITS-1:0]        setup_minor_pos;
  logic [COORD_BITS-1:0]        setup_major_delta;
  logic [COORD_BITS-1:0]        setup_minor_delta;
  logic signed [COORD_BITS+1:0] setup_error;
  logic [COORD_BITS-1:0]        major_pos_next;
  logic [COORD_BITS-1:0]        minor_pos_next;
  logic signed [COORD_BITS+1:0] error_term_next;
  logic [ADDR_W-1:0]            step_address;
  lr_pkg::step_status_t         step_status;

  logic                         advance;

  // Move a word from the input register to the result register
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_pixel;
  assign m_axis_tlast  = out_last;

  lr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .x_start     (in_data[XS_LO +: COORD_BITS]),
    .y_start     (in_data[YS_LO +: COORD_BITS]),
    .x_end       (in_data[XE_LO +: COORD_BITS]),
    .y_end       (in_data[YE_LO +: COORD_BITS]),
    .flags       (setup_flags),
    .major_pos   (setup_major_pos),
    .major_end   (setup_major_end),
    .minor_pos   (setup_minor_pos),
    .major_delta (setup_major_delta),
    .minor_delta (setup_minor_delta),
    .error_init  (setup_error)
  );

  lr_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .screen_width    (screen_width),
    .screen_height   (screen_height),
    .row_shift       (row_shift),
    .steep           (steep),
    .minor_down      (minor_down),
    .major_pos       (major_pos),
    .major_end       (major_end),
    .minor_pos       (minor_pos),
    .major_delta     (major_delta),
    .minor_delta     (minor_delta),
    .error_term      (error_term),
    .major_pos_next  (major_pos_next),
    .minor_pos_next  (minor_pos_next),
    .error_term_next (error_term_next),
    .pixel_address   (step_address),
    .status          (step_status)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lr_pkg::SCREEN_WIDTH_RST;
      screen_height <= lr_pkg::SCREEN_HEIGHT_RST;
      row_shift     <= lr_pkg::ROW_SHIFT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lr_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        lr_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        lr_pkg::REG_ROW_SHIFT:     row_shift     <= cfg_data[lr_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req  <= s_axis_tuser;
      in_data <= s_axis_tdata;
    end
  end

  // Track result register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Load or step the line and fill the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (advance) begin
      if (in_req == lr_pkg::REQ_LOAD) begin
        active <= setup_flags.active;
      end else if (active && step_status.line_finished) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_req == lr_pkg::REQ_LOAD) begin
        steep       <= setup_flags.steep;
        minor_down  <= setup_flags.minor_down;
        major_pos   <= setup_major_pos;
        major_end   <= setup_major_end;
        minor_pos   <= setup_minor_pos;
        major_delta <= setup_major_delta;
        minor_delta <= setup_minor_delta;
        error_term  <= setup_error;
        line_color  <= in_data[COLOR_LO +: COLOR_W];
        out_pixel   <= 1'b0;
        out_last    <= !setup_flags.active;
        out_data    <= '0;
      end else if (!active) begin
        out_pixel   <= 1'b0;
        out_last    <= 1'b1;
        out_data    <= '0;
      end else begin
        major_pos   <= major_pos_next;
        minor_pos   <= minor_pos_next;
        error_term  <= error_term_next;
        out_pixel   <= step_status.pixel_valid;
        out_last    <= step_status.line_finished;
        out_data    <= lr_pkg::OUT_DATA_W'({
                         (step_status.pixel_valid ? line_color : {COLOR_W{1'b0}}),
                         step_address});
      end
    end
  end

endmodule

`default_nettype wire

// File: src/lr_setup.sv
// Line setup: orders endpoints, picks the major axis and seeds the error term.
// Depends on lr_pkg for the flag struct.
`default_nettype none

module lr_setup #(
  parameter int COORD_BITS = 12
) (
  input  wire logic [COORD_BITS-1:0]   x_start,
  input  wire logic [COORD_BITS-1:0]   y_start,
  input  wire logic [COORD_BITS-1:0]   x_end,
  input  wire logic [COORD_BITS-1:0]   y_end,
  output lr_pkg::setup_flags_t         flags,
  output logic [COORD_BITS-1:0]        major_pos,
  output logic [COORD_BITS-1:0]        major_end,
  output logic [COORD_BITS-1:0]        minor_pos,
  output logic [COORD_BITS-1:0]        major_delta,
  output logic [COORD_BITS-1:0]        minor_delta,
  output logic signed [COORD_BITS+1:0] error_init
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  steep;
  logic [COORD_BITS-1:0] a0;
  logic [COORD_BITS-1:0] b0;
  logic [COORD_BITS-1:0] a1;
  logic [COORD_BITS-1:0] b1;
  logic [COORD_BITS-1:0] near_a;
  logic [COORD_BITS-1:0] near_b;
  logic [COORD_BITS-1:0] far_a;
  logic [COORD_BITS-1:0] far_b;

  // Measure both spans and pick the major axis
  always_comb begin
    dx    = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
    dy    = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);
    steep = dy > dx;
    if (steep) begin
      a0 = y_start;
      b0 = x_start;
      a1 = y_end;
      b1 = x_end;
    end else begin
      a0 = x_start;
      b0 = y_start;
      a1 = x_end;
      b1 = y_end;
    end
  end

  // Order endpoints so the major coordinate rises
  always_comb begin
    if (a1 < a0) begin
      near_a = a1;
      near_b = b1;
      far_a  = a0;
      far_b  = b0;
    end else begin
      near_a = a0;
      near_b = b0;
      far_a  = a1;
      far_b  = b1;
    end
  end

  // Seed position, deltas and error
  always_comb begin
    major_pos        = near_a;
    major_end        = far_a;
    minor_pos        = near_b;
    major_delta      = far_a - near_a;
    minor_delta      = (far_b > near_b) ? (far_b - near_b) : (near_b - far_b);
    error_init       = -$signed({3'b000, major_delta[COORD_BITS-1:1]});
    flags.steep      = steep;
    flags.minor_down = !(near_b < far_b);
    flags.active     = (major_delta != '0);
  end

endmodule

`default_nettype wire

// File: src/lr_step.sv
// Line step: clips and addresses the current pixel, then advances the error
// and both axes by one Bresenham step. Depends on lr_pkg.
`default_nettype none

module lr_step #(
  parameter int COORD_BITS = 12
) (
  input  wire logic [lr_pkg::DIM_W-1:0]   screen_width,
  input  wire logic [lr_pkg::DIM_W-1:0]   screen_height,
  input  wire logic [lr_pkg::SHIFT_W-1:0] row_shift,
  input  wire logic                       steep,
  input  wire logic                       minor_down,
  input  wire logic [COORD_BITS-1:0]      major_pos,
  input  wire logic [COORD_BITS-1:0]      major_end,
  input  wire logic [COORD_BITS-1:0]      minor_pos,
  input  wire logic [COORD_BITS-1:0]      major_delta,
  input  wire logic [COORD_BITS-1:0]      minor_delta,
  input  wire logic signed [COORD_BITS+1:0] error_term,
  output logic [COORD_BITS-1:0]           major_pos_next,
  output logic [COORD_BITS-1:0]           minor_pos_next,
  output logic signed [COORD_BITS+1:0]    error_term_next,
  output logic [lr_pkg::ADDR_W-1:0]       pixel_address,
  output lr_pkg::step_status_t            status
);

  localparam int CMP_W  = ((COORD_BITS > lr_pkg::DIM_W) ? COORD_BITS : lr_pkg::DIM_W) + 1;
  localparam int ADDR_W = lr_pkg::ADDR_W;

  logic [COORD_BITS-1:0]        sx;
  logic [COORD_BITS-1:0]        sy;
  logic                         in_screen;
  logic [ADDR_W-1:0]            row_base;
  logic [ADDR_W-1:0]            addr_sum;
  logic signed [COORD_BITS+1:0] error_sum;
  logic                         take_minor;

  // Map major/minor back to screen x and y, then clip and address
  always_comb begin
    sx        = steep ? minor_pos : major_pos;
    sy        = steep ? major_pos : minor_pos;
    in_screen = (CMP_W'(sx) < CMP_W'(screen_width)) &&
                (CMP_W'(sy) < CMP_W'(screen_height));
    row_base  = ADDR_W'(sy) << row_shift;
    addr_sum  = ADDR_W'(sx) + row_base;
    pixel_address = in_screen ? addr_sum : '0;
  end

  // Advance the error and both axes
  always_comb begin
    error_sum  = error_term + $signed({2'b00, minor_delta});
    take_minor = !error_sum[COORD_BITS+1];
    if (take_minor) begin
      error_term_next = error_sum - $signed({2'b00, major_delta});
      minor_pos_next  = minor_down ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
    end else begin
      error_term_next = error_sum;
      minor_pos_next  = minor_pos;
    end
    major_pos_next       = major_pos + 1'b1;
    status.pixel_valid   = in_screen;
    status.line_finished = (major_pos_next == major_end);
  end

endmodule

`default_nettype wire

// File: tb/line_rasterizer_checker.sv
// Result checker for line_rasterizer: watches the request, result and register
// channels, predicts one result word per request word and compares field by field.
// Depends on lr_pkg.
module line_rasterizer_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  // x_start, y_start, x_end, y_end, color from bit 0
  input  wire logic [63:0]                     s_axis_tdata,
  // req_type
  input  wire logic                            s_axis_tuser,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // pixel_address, pixel_color from bit 0
  input  wire logic [lr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // pixel_valid
  input  wire logic                            m_axis_tuser,
  input  wire logic                            m_axis_tlast,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [lr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [lr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                   fail_count,
  output int                                   pending
);
  import lr_pkg::*;

  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               finished;
  } pixel_word_t;

  pixel_word_t pending_pixels[$];

  // Screen geometry as last written
  logic [DIM_W-1:0]   scr_width;
  logic [DIM_W-1:0]   scr_height;
  logic [SHIFT_W-1:0] scr_shift;

  // Line being drawn
  logic        ln_active;
  logic        ln_steep;
  logic        ln_minor_down;
  logic [11:0] ln_major_pos;
  logic [11:0] ln_major_end;
  logic [11:0] ln_minor_pos;
  logic [11:0] ln_major_delta;
  logic [11:0] ln_minor_delta;
  int          ln_error;
  logic [15:0] ln_color;

  // Advance the line state by one request word and return the word it yields
  function automatic pixel_word_t rasterize_word(input logic req, input logic [63:0] d);
    pixel_word_t res;
    logic [11:0] xs, ys, xe, ye, a0, b0, a1, b1, sx, sy, dx, dy;
    logic [63:0] full_addr;
    res = '0;
    xs = d[11:0];
    ys = d[23:12];
    xe = d[35:24];
    ye = d[47:36];
    if (req == REQ_LOAD) begin
      dx = (xe > xs) ? xe - xs : xs - xe;
      dy = (ye > ys) ? ye - ys : ys - ye;
      ln_steep = dy > dx;
      if (ln_steep) begin
        a0 = ys; b0 = xs; a1 = ye; b1 = xe;
      end else begin
        a0 = xs; b0 = ys; a1 = xe; b1 = ye;
      end
      // order the endpoints so the major coordinate rises
      if (a1 < a0) begin
        {a0, a1} = {a1, a0};
        {b0, b1} = {b1, b0};
      end
      ln_major_pos   = a0;
      ln_major_end   = a1;
      ln_minor_pos   = b0;
      ln_minor_down  = !(b0 < b1);
      ln_major_delta = a1 - a0;
      ln_minor_delta = (b1 > b0) ? b1 - b0 : b0 - b1;
      ln_error       = -int'(ln_major_delta >> 1);
      ln_color       = d[63:48];
      ln_active      = ln_major_delta != 12'd0;
      res.finished   = !ln_active;
    end else if (!ln_active) begin
      res.finished = 1'b1;
    end else begin
      sx = ln_steep ? ln_minor_pos : ln_major_pos;
      sy = ln_steep ? ln_major_pos : ln_minor_pos;
      // clip against the screen, wrap the address to the buffer
      if (sx < {1'b0, scr_width} && sy < {1'b0, scr_height}) begin
        full_addr = 64'(sx) + (64'(sy) << scr_shift);
        res.valid = 1'b1;
        res.addr  = full_addr[ADDR_W-1:0];
        res.color = ln_color;
      end
      ln_error = ln_error + int'(ln_minor_delta);
      if (ln_error >= 0) begin
        ln_minor_pos = ln_minor_down ? ln_minor_pos - 12'd1 : ln_minor_pos + 12'd1;
        ln_error     = ln_error - int'(ln_major_delta);
      end
      ln_major_pos = ln_major_pos + 12'd1;
      if (ln_major_pos == ln_major_end) begin
        ln_active    = 1'b0;
        res.finished = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_word_t want;
    if (rst) begin
      scr_width      = SCREEN_WIDTH_RST;
      scr_height     = SCREEN_HEIGHT_RST;
      scr_shift      = ROW_SHIFT_RST;
      ln_active      = 1'b0;
      ln_steep       = 1'b0;
      ln_minor_down  = 1'b0;
      ln_major_pos   = '0;
      ln_major_end   = '0;
      ln_minor_pos   = '0;
      ln_major_delta = '0;
      ln_minor_delta = '0;
      ln_error       = 0;
      ln_color       = '0;
      pending_pixels.delete();
      fail_count     = 0;
      pending        = 0;
    end else begin
      // take register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  scr_width  = cfg_data;
          REG_SCREEN_HEIGHT: scr_height = cfg_data;
          REG_ROW_SHIFT:     scr_shift  = cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      // compare a result word with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result word: valid %b addr %h last %b", $time,
                   m_axis_tuser, m_axis_tdata[ADDR_W-1:0], m_axis_tlast);
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_valid", 32'(want.valid), 32'(m_axis_tuser));
          check_field("pixel_address", 32'(want.addr), 32'(m_axis_tdata[ADDR_W-1:0]));
          check_field("pixel_color", 32'(want.color),
                      32'(m_axis_tdata[ADDR_W+COLOR_W-1:ADDR_W]));
          check_field("line_finished", 32'(want.finished), 32'(m_axis_tlast));
        end
      end
      // predict the word for each accepted request
      if (s_axis_tvalid && s_axis_tready)
        pending_pixels.push_back(rasterize_word(s_axis_tuser, s_axis_tdata));
      pending = pending_pixels.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Top of the line_rasterizer testbench: clock, reset, request and register
// stimulus with random idling, and the verdict. Uses lr_pkg, line_rasterizer
// and line_rasterizer_checker.
module tb_top;
  import lr_pkg::*;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  // x_start, y_start, x_end, y_end, color from bit 0
  logic [63:0]                s_axis_tdata = '0;
  // req_type
  logic                       s_axis_tuser = REQ_LOAD;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // pixel_address, pixel_color from bit 0
  logic [OUT_DATA_W-1:0]      m_axis_tdata;
  // pixel_valid
  logic                       m_axis_tuser;
  logic                       m_axis_tlast;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_W-1:0]     cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  int                         fail_count;
  int                         pending;

  int words_sent = 0;
  int cur_width  = 320;
  int cur_height = 240;
  bit calm       = 1'b0;

  line_rasterizer uut (.*);
  line_rasterizer_checker chk (.*);

  always #4 clk = ~clk;

  // Idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // Mostly near the visible area so pixels land on screen
  function automatic int pick_coord(input int lim);
    if ($urandom_range(0, 99) < 60) return clamp_coord($urandom_range(0, lim + 4));
    return $urandom_range(0, 4095);
  endfunction

  // Drive one request word; entered and left at a falling edge
  task automatic send_word(input logic req, input int xs, input int ys, input int xe,
                           input int ye, input int col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {16'(col), 12'(ye), 12'(xe), 12'(ys), 12'(xs)};
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_step();
    send_word(REQ_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Write one register; caller lowers cfg_valid after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 11'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SCREEN_WIDTH) cur_width = val;
    if (idx == REG_SCREEN_HEIGHT) cur_height = val;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_screen(input int w, input int h, input int sh);
    drain();
    write_reg(REG_ROW_SHIFT, sh);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Load a random line and step through it, sometimes cut short or overrun
  task automatic draw_random_line();
    int r, lmaj, lmin, dx, dy, x0, y0, x1, y1, steps;
    r = $urandom_range(0, 99);
    if (r < 75) lmaj = $urandom_range(0, 12);
    else if (r < 95) lmaj = $urandom_range(13, 48);
    else if (r < 99) lmaj = $urandom_range(49, 256);
    else lmaj = $urandom_range(257, 4095);
    lmin = ($urandom_range(0, 9) == 0) ? lmaj : $urandom_range(0, lmaj);
    x0 = pick_coord(cur_width);
    y0 = pick_coord(cur_height);
    if ($urandom_range(0, 1) != 0) begin
      dx = lmaj; dy = lmin;
    end else begin
      dx = lmin; dy = lmaj;
    end
    if ($urandom_range(0, 1) != 0) dx = -dx;
    if ($urandom_range(0, 1) != 0) dy = -dy;
    x1 = clamp_coord(x0 + dx);
    y1 = clamp_coord(y0 + dy);
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    steps = (dx > dy) ? dx : dy;
    send_word(REQ_LOAD, x0, y0, x1, y1, $urandom);
    // cut some lines so the next load replaces a busy one
    r = $urandom_range(0, 99);
    if (steps > 256) steps = $urandom_range(1, 200);
    else if (r < 15 && steps > 0) steps = $urandom_range(0, steps - 1);
    repeat (steps) send_step();
    // step past the end now and then
    if (r >= 90) repeat ($urandom_range(1, 3)) send_step();
  endtask

  task automatic random_phase(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(0, 19) == 0) send_step();
      else draw_random_line();
    end
  endtask

  // Result side: ready in bursts with random stalls
  initial begin
    int hold;
    @(negedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    #30000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: idle step, zero-length line, long diagonal, load while busy,
    // reversed and steep lines, clipping at the screen edge
    send_step();
    send_word(REQ_LOAD, 5, 5, 5, 5, 16'hffff);
    send_step();
    send_word(REQ_LOAD, 0, 0, 4095, 4095, 0);
    repeat (3) send_step();
    send_word(REQ_LOAD, 4095, 0, 0, 3, 16'h1234);
    repeat (2) send_step();
    send_word(REQ_LOAD, 100, 200, 98, 203, 16'habcd);
    repeat (4) send_step();
    send_word(REQ_LOAD, 319, 239, 321, 240, 16'h5a5a);
    repeat (2) send_step();
    send_word(REQ_LOAD, 0, 4095, 1, 4095, 16'haaaa);
    send_step();

    // Random phases across screen settings, extremes included
    random_phase(90);
    set_screen(1024, 1024, 11);
    random_phase(90);
    set_screen(1, 1, 0);
    random_phase(90);
    set_screen(0, 5, 4);
    random_phase(90);
    set_screen(2047, 2047, 15);
    random_phase(90);
    set_screen(640, 480, 10);
    calm = 1'b1;
    random_phase(90);
    calm = 1'b0;
    set_screen($urandom_range(1, 1024), $urandom_range(1, 1024), $urandom_range(0, 11));
    random_phase(90);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
